>>> rtl/core/cfds_pkg.sv
// cfds_pkg: shared types, constants and helpers for the cubic forward difference stepper
// used by cfds_div and cubic_forward_difference_stepper_core; no dependencies
package cfds_pkg;

    localparam int COEF_W     = 32;
    localparam int COEF_FRAC  = 16;
    localparam int ACC_W      = 64;
    localparam int AXES       = 3;
    localparam int ROW_LEN    = 4;
    localparam int STEP_W     = 11;
    localparam int DIVIDEND_W = 34;   // |coef| * 6 fits in 34 bits
    localparam int DIVISOR_W  = 33;   // n^3 with n below 2^11
    localparam int QUOT_W     = 63;
    localparam int POINT_XY_W = 24;
    localparam int POINT_Z_W  = 32;

    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_STEP = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_CUBE,
        ST_ISSUE,
        ST_WAIT,
        ST_WRITE
    } state_t;

    typedef enum logic [2:0] {
        TERM_CONST,
        TERM_LIN,
        TERM_SQ,
        TERM_CUB,
        TERM_CUB6,
        TERM_SQ2
    } term_t;

    typedef struct packed {
        logic                  start;
        logic [DIVIDEND_W-1:0] dividend;
        logic [DIVISOR_W-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [QUOT_W-1:0] quotient;
    } div_rsp_t;

    function automatic logic signed [ACC_W-1:0] sat_add(
        input logic signed [ACC_W-1:0] p,
        input logic signed [ACC_W-1:0] q
    );
        logic signed [ACC_W-1:0] s;
        s = p + q;
        if ((p[ACC_W-1] == q[ACC_W-1]) && (s[ACC_W-1] != p[ACC_W-1]))
        begin
            if (p[ACC_W-1])
            begin
                sat_add = {1'b1, {(ACC_W-1){1'b0}}};
            end
            else
            begin
                sat_add = {1'b0, {(ACC_W-1){1'b1}}};
            end
        end
        else
        begin
            sat_add = s;
        end
    endfunction

endpackage

>>> rtl/core/cfds_div.sv
// cfds_div: restoring divider, one quotient bit per cycle, dividend scaled by 2^SHIFT_BITS
// quotient saturates at 2^63-1; depends on cfds_pkg
module cfds_div #(
    parameter int SHIFT_BITS = 24
) (
    input  logic                clk,
    input  logic                rst_n,
    input  cfds_pkg::div_req_t  req,
    output cfds_pkg::div_rsp_t  rsp
);

    localparam int XW = cfds_pkg::DIVIDEND_W;
    localparam int DW = XW + SHIFT_BITS;
    localparam int CW = $clog2(DW + 1);
    localparam int VW = cfds_pkg::DIVISOR_W;
    localparam int QW = cfds_pkg::QUOT_W;

    logic          busy_reg;
    logic          busy_next;
    logic          done_reg;
    logic          done_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic [DW-1:0] num_reg;
    logic [DW-1:0] num_next;
    logic [VW:0]   rem_reg;
    logic [VW:0]   rem_next;
    logic [VW-1:0] den_reg;
    logic [VW-1:0] den_next;
    logic [QW-1:0] quo_reg;
    logic [QW-1:0] quo_next;
    logic          sat_reg;
    logic          sat_next;

    logic [VW:0]   rem_sh;
    logic [VW+1:0] diff;

    always_comb
    begin
        rem_sh     = {rem_reg[VW-1:0], num_reg[DW-1]};
        diff       = {1'b0, rem_sh} - {2'b00, den_reg};
        busy_next  = busy_reg;
        done_next  = 1'b0;
        count_next = count_reg;
        num_next   = num_reg;
        rem_next   = rem_reg;
        den_next   = den_reg;
        quo_next   = quo_reg;
        sat_next   = sat_reg;
        if (req.start)
        begin
            busy_next  = 1'b1;
            count_next = CW'(DW);
            num_next   = {req.dividend, {SHIFT_BITS{1'b0}}};
            rem_next   = '0;
            den_next   = req.divisor;
            quo_next   = '0;
            sat_next   = 1'b0;
        end
        else if (busy_reg)
        begin
            num_next   = {num_reg[DW-2:0], 1'b0};
            rem_next   = diff[VW+1] ? rem_sh : diff[VW:0];
            // a bit leaving the top means the quotient passed 2^63-1
            sat_next   = sat_reg | quo_reg[QW-1];
            quo_next   = {quo_reg[QW-2:0], ~diff[VW+1]};
            count_next = count_reg - CW'(1);
            if (count_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
        quo_reg <= quo_next;
        sat_reg <= sat_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = sat_reg ? {QW{1'b1}} : quo_reg;

endmodule

>>> rtl/core/cubic_forward_difference_stepper_core.sv
// cubic_forward_difference_stepper_core: top level of the cubic curve stepper
// depends on cfds_pkg and cfds_div
//
// input items on s_axis: tuser bit 0 selects load (0) or step (1), tuser bits 2:1 the
// axis to load; tdata carries the cubic, square, linear and constant coefficients (Q16.16).
// a load sets one axis's value and three differences for the current step_count, using
// the shared restoring divider for each of six scaled terms, one bit per cycle. a load
// keeps s_axis_tready low until its row is written.
// a load with axis 3 is dropped at once and gives no item.
// a step is taken at acceptance: all three axes advance and the point is registered on
// m_axis in the cycle after acceptance; steps may follow back to back.
// a waiting point does not block the next step when m_axis_tready is high in that cycle;
// while m_axis holds an item that is not taken, s_axis_tready stays low.
// the user is to write step_count through cfg_we/cfg_wdata only while the block is idle; the
// block does not enforce this. 0 acts as 1 and values above MAX_STEPS act as MAX_STEPS.
// reset clears all accumulators to zero, sets step_count to 16 and empties m_axis.
module cubic_forward_difference_stepper_core #(
    parameter int MAX_STEPS     = 1024,
    parameter int ACC_FRAC_BITS = 40
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [10:0]  cfg_wdata,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [127:0] s_axis_tdata,   // coeff_cubic, coeff_square, coeff_linear, coeff_const
    input  logic [2:0]   s_axis_tuser,   // action, axis
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [79:0]  m_axis_tdata    // point_x, point_y, point_z
);

    localparam int CW    = cfds_pkg::COEF_W;
    localparam int AW    = cfds_pkg::ACC_W;
    localparam int NW    = cfds_pkg::STEP_W;
    localparam int XW    = cfds_pkg::DIVIDEND_W;
    localparam int VW    = cfds_pkg::DIVISOR_W;
    localparam int AXES  = cfds_pkg::AXES;
    localparam int RLEN  = cfds_pkg::ROW_LEN;
    localparam int PXW   = cfds_pkg::POINT_XY_W;
    localparam int PZW   = cfds_pkg::POINT_Z_W;
    localparam int ZSH   = ACC_FRAC_BITS - cfds_pkg::COEF_FRAC;

    cfds_pkg::state_t state_reg;
    cfds_pkg::state_t state_next;
    cfds_pkg::term_t  term_reg;
    cfds_pkg::term_t  term_next;

    logic [NW-1:0]     step_count_reg;
    logic [NW-1:0]     n_eff;
    logic [NW-1:0]     n_reg;
    logic [2*NW-1:0]   n2_reg;
    logic [3*NW-1:0]   n3_reg;
    logic [1:0]        axis_reg;
    logic signed [CW-1:0] a_reg;
    logic signed [CW-1:0] b_reg;
    logic signed [CW-1:0] c_reg;
    logic signed [CW-1:0] e_reg;

    logic signed [AW-1:0] diff_reg [AXES][RLEN];
    logic signed [AW-1:0] row_reg  [RLEN];
    logic signed [AW-1:0] step_row [AXES][RLEN-1];

    logic                 out_valid_reg;
    logic [79:0]          out_data_reg;

    logic                 in_acc;
    logic                 step_acc;
    logic                 load_acc;

    logic signed [CW-1:0] coef_sel;
    logic [CW-1:0]        mag;
    logic [XW-1:0]        scaled;
    logic [VW-1:0]        den_sel;
    logic signed [AW-1:0] term_mag;
    logic signed [AW-1:0] term_val;

    cfds_pkg::div_req_t div_req;
    cfds_pkg::div_rsp_t div_rsp;

    cfds_div #(
        .SHIFT_BITS (ZSH)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    function automatic logic [PXW-1:0] pack_int24(input logic signed [AW-1:0] acc);
        logic signed [AW:0] ip;
        logic               bump;
        bump = acc[AW-1] & (|acc[ACC_FRAC_BITS-1:0]);
        // floor plus one for a negative value with a fraction gives truncation
        ip = ($signed({acc[AW-1], acc}) >>> ACC_FRAC_BITS) + $signed({{AW{1'b0}}, bump});
        if (ip > 65'sd8388607)
        begin
            pack_int24 = {1'b0, {(PXW-1){1'b1}}};
        end
        else if (ip < -65'sd8388608)
        begin
            pack_int24 = {1'b1, {(PXW-1){1'b0}}};
        end
        else
        begin
            pack_int24 = ip[PXW-1:0];
        end
    endfunction

    function automatic logic [PZW-1:0] pack_q16(input logic signed [AW-1:0] acc);
        logic signed [AW:0] v;
        logic               bump;
        bump = acc[AW-1] & (|acc[ZSH-1:0]);
        v = ($signed({acc[AW-1], acc}) >>> ZSH) + $signed({{AW{1'b0}}, bump});
        if (v > 65'sd2147483647)
        begin
            pack_q16 = {1'b0, {(PZW-1){1'b1}}};
        end
        else if (v < -65'sd2147483648)
        begin
            pack_q16 = {1'b1, {(PZW-1){1'b0}}};
        end
        else
        begin
            pack_q16 = v[PZW-1:0];
        end
    endfunction

    assign s_axis_tready = (state_reg == cfds_pkg::ST_IDLE) && (!out_valid_reg || m_axis_tready);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign step_acc      = in_acc && (s_axis_tuser[0] == cfds_pkg::ACT_STEP);
    assign load_acc      = in_acc && (s_axis_tuser[0] == cfds_pkg::ACT_LOAD)
                           && (s_axis_tuser[2:1] < 2'(AXES));
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    always_comb
    begin
        if (step_count_reg == '0)
        begin
            n_eff = NW'(1);
        end
        else if (32'(step_count_reg) > 32'(MAX_STEPS))
        begin
            n_eff = NW'(MAX_STEPS);
        end
        else
        begin
            n_eff = step_count_reg;
        end
    end

    // step: every add sees the old value of its right operand
    always_comb
    begin
        for (int ax = 0; ax < AXES; ax++)
        begin
            for (int k = 0; k < RLEN - 1; k++)
            begin
                step_row[ax][k] = cfds_pkg::sat_add(diff_reg[ax][k], diff_reg[ax][k+1]);
            end
        end
    end

    // operand selection for the term in flight
    always_comb
    begin
        coef_sel = e_reg;
        den_sel  = VW'(1);
        case (term_reg) inside
            cfds_pkg::TERM_CONST:
            begin
                coef_sel = e_reg;
                den_sel  = VW'(1);
            end
            cfds_pkg::TERM_LIN:
            begin
                coef_sel = c_reg;
                den_sel  = VW'(n_reg);
            end
            cfds_pkg::TERM_SQ, cfds_pkg::TERM_SQ2:
            begin
                coef_sel = b_reg;
                den_sel  = VW'(n2_reg);
            end
            cfds_pkg::TERM_CUB, cfds_pkg::TERM_CUB6:
            begin
                coef_sel = a_reg;
                den_sel  = VW'(n3_reg);
            end
            default:
            begin
                coef_sel = e_reg;
                den_sel  = VW'(1);
            end
        endcase
        mag = coef_sel[CW-1] ? (~coef_sel + CW'(1)) : coef_sel;
        case (term_reg)
            cfds_pkg::TERM_SQ2:  scaled = {1'b0, mag, 1'b0};
            cfds_pkg::TERM_CUB6: scaled = {1'b0, mag, 1'b0} + {mag, 2'b00};
            default:             scaled = {2'b00, mag};
        endcase
        term_mag = $signed({1'b0, div_rsp.quotient});
        term_val = coef_sel[CW-1] ? -term_mag : term_mag;
    end

    always_comb
    begin
        state_next       = state_reg;
        term_next        = term_reg;
        div_req.start    = 1'b0;
        div_req.dividend = scaled;
        div_req.divisor  = den_sel;
        unique case (state_reg)
            cfds_pkg::ST_IDLE:
            begin
                if (load_acc)
                begin
                    state_next = cfds_pkg::ST_SQUARE;
                end
            end
            cfds_pkg::ST_SQUARE:
            begin
                state_next = cfds_pkg::ST_CUBE;
            end
            cfds_pkg::ST_CUBE:
            begin
                state_next = cfds_pkg::ST_ISSUE;
                term_next  = cfds_pkg::TERM_CONST;
            end
            cfds_pkg::ST_ISSUE:
            begin
                div_req.start = 1'b1;
                state_next    = cfds_pkg::ST_WAIT;
            end
            cfds_pkg::ST_WAIT:
            begin
                if (div_rsp.done)
                begin
                    state_next = cfds_pkg::ST_ISSUE;
                    unique case (term_reg)
                        cfds_pkg::TERM_CONST: term_next = cfds_pkg::TERM_LIN;
                        cfds_pkg::TERM_LIN:   term_next = cfds_pkg::TERM_SQ;
                        cfds_pkg::TERM_SQ:    term_next = cfds_pkg::TERM_CUB;
                        cfds_pkg::TERM_CUB:   term_next = cfds_pkg::TERM_CUB6;
                        cfds_pkg::TERM_CUB6:  term_next = cfds_pkg::TERM_SQ2;
                        default:              state_next = cfds_pkg::ST_WRITE;
                    endcase
                end
            end
            cfds_pkg::ST_WRITE:
            begin
                state_next = cfds_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = cfds_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= cfds_pkg::ST_IDLE;
            term_reg       <= cfds_pkg::TERM_CONST;
            step_count_reg <= NW'(16);
            out_valid_reg  <= 1'b0;
            for (int ax = 0; ax < AXES; ax++)
            begin
                for (int k = 0; k < RLEN; k++)
                begin
                    diff_reg[ax][k] <= '0;
                end
            end
        end
        else
        begin
            state_reg <= state_next;
            term_reg  <= term_next;
            if (cfg_we)
            begin
                step_count_reg <= cfg_wdata;
            end
            if (step_acc)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (step_acc)
            begin
                for (int ax = 0; ax < AXES; ax++)
                begin
                    for (int k = 0; k < RLEN - 1; k++)
                    begin
                        diff_reg[ax][k] <= step_row[ax][k];
                    end
                end
            end
            else if (state_reg == cfds_pkg::ST_WRITE)
            begin
                for (int k = 0; k < RLEN; k++)
                begin
                    diff_reg[axis_reg][k] <= row_reg[k];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_acc)
        begin
            axis_reg <= s_axis_tuser[2:1];
            a_reg    <= s_axis_tdata[31:0];
            b_reg    <= s_axis_tdata[63:32];
            c_reg    <= s_axis_tdata[95:64];
            e_reg    <= s_axis_tdata[127:96];
            n_reg    <= n_eff;
        end
        if (state_reg == cfds_pkg::ST_SQUARE)
        begin
            n2_reg <= (2*NW)'(n_reg) * (2*NW)'(n_reg);
        end
        if (state_reg == cfds_pkg::ST_CUBE)
        begin
            n3_reg <= (3*NW)'(n2_reg) * (3*NW)'(n_reg);
        end
        if ((state_reg == cfds_pkg::ST_WAIT) && div_rsp.done)
        begin
            case (term_reg) inside
                cfds_pkg::TERM_CONST: row_reg[0] <= term_val;
                cfds_pkg::TERM_LIN:   row_reg[1] <= term_val;
                cfds_pkg::TERM_SQ, cfds_pkg::TERM_CUB:
                begin
                    row_reg[1] <= cfds_pkg::sat_add(row_reg[1], term_val);
                end
                cfds_pkg::TERM_CUB6:  row_reg[3] <= term_val;
                default:              row_reg[2] <= cfds_pkg::sat_add(term_val, row_reg[3]);
            endcase
        end
        if (step_acc)
        begin
            out_data_reg <= {pack_q16(step_row[2][0]), pack_int24(step_row[1][0]),
                             pack_int24(step_row[0][0])};
        end
    end

    a_no_accept_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
        else $error("input accepted while a point is stalled");

    a_third_diff_kept: assert property (@(posedge clk) disable iff (!rst_n)
        step_acc |=> ($stable(diff_reg[0][3]) && $stable(diff_reg[1][3])
                      && $stable(diff_reg[2][3])))
        else $error("step changed a third difference");

    a_wait_ends_on_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == cfds_pkg::ST_WAIT && state_next != cfds_pkg::ST_WAIT) |-> div_rsp.done)
        else $error("term sequence moved on without a quotient");

    a_divisor_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != cfds_pkg::ST_IDLE) |-> (n_reg != '0))
        else $error("load running with a zero step count");

    a_point_from_step: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(step_acc))
        else $error("point shown without a step");

endmodule
